/* rtl/ttcg_pkg.sv */
package ttcg_pkg;

	// fixed field widths
	localparam int ALPHA_W    = 9;
	localparam int ALPHA_FRAC = 8;    // alpha is in 256ths
	localparam int HOLD_W     = 8;
	localparam int LEVEL_W    = 8;
	localparam int TREND_W    = 2;
	localparam int PCT_W      = 7;    // 0..100
	localparam int CNT_W      = $clog2(ALPHA_W);
	localparam int IDX_W      = 2;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_ALPHA = 2'd0,
		CFG_T_MIN = 2'd1,
		CFG_T_MAX = 2'd2,
		CFG_HOLD  = 2'd3
	} cfg_idx_t;

	// register reset values
	localparam int ALPHA_RST = 26;
	localparam int T_MIN_RST = 80;
	localparam int T_MAX_RST = 400;
	localparam int HOLD_RST  = 10;

	// item operations
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FORCE  = 1'b1;

	localparam logic [TREND_W-1:0] TREND_RISING  = 2'd0;
	localparam logic [TREND_W-1:0] TREND_FALLING = 2'd1;
	localparam logic [TREND_W-1:0] TREND_STEADY  = 2'd2;

	localparam int YELLOW_PCT = 10;
	localparam int FULL_PCT   = 100;
	localparam int FULL_LEVEL = 255;

	// floor(x/10) = (x*RECIP10)>>RECIP10_SH for x < 16384
	// floor(x/90) = (x*RECIP90)>>RECIP90_SH for x < 74898
	localparam int RECIP10    = 3277;
	localparam int RECIP10_SH = 15;
	localparam int RECIP90    = 23302;
	localparam int RECIP90_SH = 21;
	localparam int LVL_W      = PCT_W + LEVEL_W;           // 255 * pct
	localparam int RPROD_W    = LVL_W + 15;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

endpackage

/* rtl/ttcg_if.sv */
interface ttcg_sample_if import ttcg_pkg::*; #(
	parameter int TEMP_BITS = 12
);
	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [TEMP_BITS-1:0] temperature;
	logic                 probe_open;

	modport source (output valid, operation, temperature, probe_open, input ready);
	modport sink   (input valid, operation, temperature, probe_open, output ready);
endinterface

interface ttcg_gauge_if import ttcg_pkg::*; #(
	parameter int AVG_BITS = 20
);
	logic                valid;
	logic                ready;
	logic [LEVEL_W-1:0]  red;
	logic [LEVEL_W-1:0]  green;
	logic [LEVEL_W-1:0]  blue;
	logic [TREND_W-1:0]  trend;
	logic [AVG_BITS-1:0] average;
	logic                average_valid;

	modport source (output valid, red, green, blue, trend, average, average_valid,
		input ready);
	modport sink   (input valid, red, green, blue, trend, average, average_valid,
		output ready);
endinterface

/* rtl/temp_trend_and_colour_gauge_unit.sv */
// Temperature trend and colour gauge.
//
// sample channel: one item per thermocouple reading (operation, temperature in
// quarter degrees, probe_open). operation 0 updates the moving average and the
// trend, operation 1 only recolours. gauge channel: one item per sample item,
// carrying the colour, the held trend and the average with its valid bit.
// cfg_we/cfg_index/cfg_data write the four registers; write only while idle.
//
// Sequence: an item is accepted in the idle state, then the run state does the
// work (the bit-serial alpha multiply sets its length; the 7-step percent
// divider runs beside it) and the finish state commits the result to the output
// register. A new item is accepted only once the previous one has committed.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following item stops in its finish cycle
// and state is not committed until the output register frees.
//
// Reset: registers take their defaults, the average is invalid and zero, the
// trend is steady and the hold counter is zero.
module temp_trend_and_colour_gauge_unit import ttcg_pkg::*; #(
	parameter int TEMP_BITS     = 12,
	parameter int EMA_FRAC_BITS = 8,
	localparam int AVG_W = TEMP_BITS + EMA_FRAC_BITS,
	localparam int CFG_W = (TEMP_BITS > ALPHA_W) ? TEMP_BITS : ALPHA_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	ttcg_sample_if.sink      sample,
	ttcg_gauge_if.source     gauge
);

	localparam int DIFF_W = AVG_W + 1;
	localparam int PROD_W = DIFF_W + ALPHA_W;
	localparam int NUM_W  = TEMP_BITS + PCT_W;

	// configuration
	logic [ALPHA_W-1:0]   alpha_q;
	logic [TEMP_BITS-1:0] t_min_q, t_max_q;
	logic [HOLD_W-1:0]    hold_count_q;

	// block state
	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [AVG_W-1:0]     ema_q;
	logic                 ema_ok_q;
	logic [TREND_W-1:0]   trend_q;
	logic [HOLD_W-1:0]    hold_q;

	// item in work
	logic                 op_q, open_q, fix_q;
	logic [PCT_W-1:0]     pfix_q;
	logic [AVG_W-1:0]     base_q;
	logic [ALPHA_W-1:0]   a_q;
	logic signed [PROD_W-1:0] md_q, acc_q;
	logic [TEMP_BITS-1:0] rem_q, den_q;
	logic [PCT_W-1:0]     quo_q;

	// output register
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   red_q, green_q, blue_q;
	logic [TREND_W-1:0]   otrend_q;
	logic [AVG_W-1:0]     avg_q;
	logic                 avg_ok_q;

	logic accept, commit;
	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign commit       = (state_q == ST_FIN) && (!out_valid_q || gauge.ready);

	// set up of the multiply and divide at accept
	logic [AVG_W-1:0]         base_w, target_w;
	logic signed [DIFF_W-1:0] diff_w;
	logic [TEMP_BITS-1:0]     n_w, d_w;
	logic [NUM_W-1:0]         num_w;
	logic                     fix_w;
	logic [PCT_W-1:0]         pfix_w;

	always_comb begin
		base_w   = ema_ok_q ? ema_q : '0;
		target_w = {sample.temperature, {EMA_FRAC_BITS{1'b0}}};
		diff_w   = $signed({1'b0, target_w}) - $signed({1'b0, base_w});
		n_w      = sample.temperature - t_min_q;
		d_w      = t_max_q - t_min_q;
		num_w    = NUM_W'(n_w) * NUM_W'(FULL_PCT) + NUM_W'(d_w) - NUM_W'(1);
		fix_w    = 1'b1;
		pfix_w   = '0;
		if (sample.temperature < t_min_q) begin
			pfix_w = '0;
		end else if (sample.temperature > t_max_q) begin
			pfix_w = PCT_W'(FULL_PCT);
		end else if (t_max_q == t_min_q) begin
			pfix_w = '0;
		end else begin
			fix_w = 1'b0;
		end
	end

	// one restoring divide step
	logic [TEMP_BITS:0] trial_w;
	logic               qbit_w;
	assign trial_w = {rem_q, quo_q[PCT_W-1]};
	assign qbit_w  = (trial_w >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= sample.operation;
			open_q <= sample.probe_open;
			fix_q  <= fix_w;
			pfix_q <= pfix_w;
			base_q <= base_w;
			a_q    <= alpha_q;
			md_q   <= {{ALPHA_W{diff_w[DIFF_W-1]}}, diff_w};
			acc_q  <= '0;
			// quotient is below 128, so the high part is already below the divisor
			rem_q  <= num_w[NUM_W-1:PCT_W];
			quo_q  <= num_w[PCT_W-1:0];
			den_q  <= d_w;
		end else if (state_q == ST_RUN) begin
			if (a_q[0]) begin
				acc_q <= acc_q + md_q;
			end
			md_q <= md_q <<< 1;
			a_q  <= a_q >> 1;
			if (cnt_q < CNT_W'(PCT_W)) begin
				rem_q <= qbit_w ? TEMP_BITS'(trial_w - {1'b0, den_q})
				                : trial_w[TEMP_BITS-1:0];
				quo_q <= {quo_q[PCT_W-2:0], qbit_w};
			end
		end
	end

	// finish: average clamp, trend, colour
	logic signed [PROD_W-1:0] res_w;
	logic [AVG_W-1:0]         next_w;
	logic [TREND_W-1:0]       trend_w;
	logic [PCT_W-1:0]         pct_w;
	logic [LVL_W-1:0]         lvl_lo_w, lvl_hi_w;
	logic [RPROD_W-1:0]       rp10_w, rp90_w;
	logic [LEVEL_W-1:0]       red_w, green_w, blue_w;

	always_comb begin
		res_w = $signed({{(PROD_W-AVG_W){1'b0}}, base_q}) + (acc_q >>> ALPHA_FRAC);
		if (open_q || res_w[PROD_W-1]) begin
			next_w = '0;
		end else if (res_w[PROD_W-2:AVG_W] != '0) begin
			next_w = '1;
		end else begin
			next_w = res_w[AVG_W-1:0];
		end

		if (!ema_ok_q || open_q) begin
			trend_w = TREND_STEADY;
		end else if (next_w > ema_q) begin
			trend_w = TREND_RISING;
		end else if (next_w < ema_q) begin
			trend_w = TREND_FALLING;
		end else begin
			trend_w = TREND_STEADY;
		end

		pct_w    = fix_q ? pfix_q : quo_q;
		// 255 * x as a shift and subtract
		lvl_lo_w = {pct_w, {LEVEL_W{1'b0}}} - LVL_W'(pct_w);
		lvl_hi_w = {PCT_W'(FULL_PCT) - pct_w, {LEVEL_W{1'b0}}}
		           - LVL_W'(PCT_W'(FULL_PCT) - pct_w);
		rp10_w   = RPROD_W'(lvl_lo_w) * RPROD_W'(RECIP10);
		rp90_w   = RPROD_W'(lvl_hi_w) * RPROD_W'(RECIP90);
		if (open_q) begin
			red_w   = '0;
			green_w = '0;
			blue_w  = LEVEL_W'(FULL_LEVEL);
		end else if (pct_w <= PCT_W'(YELLOW_PCT)) begin
			red_w   = LEVEL_W'(rp10_w >> RECIP10_SH);
			green_w = LEVEL_W'(FULL_LEVEL);
			blue_w  = '0;
		end else begin
			red_w   = LEVEL_W'(FULL_LEVEL);
			green_w = LEVEL_W'(rp90_w >> RECIP90_SH);
			blue_w  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			red_q   <= red_w;
			green_q <= green_w;
			blue_q  <= blue_w;
			if (op_q == OP_SAMPLE) begin
				avg_q    <= next_w;
				avg_ok_q <= !open_q;
				otrend_q <= (hold_q != '0) ? trend_q : trend_w;
			end else begin
				avg_q    <= ema_q;
				avg_ok_q <= ema_ok_q;
				otrend_q <= trend_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= ALPHA_W'(ALPHA_RST);
			t_min_q      <= TEMP_BITS'(T_MIN_RST);
			t_max_q      <= TEMP_BITS'(T_MAX_RST);
			hold_count_q <= HOLD_W'(HOLD_RST);
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			ema_q        <= '0;
			ema_ok_q     <= 1'b0;
			trend_q      <= TREND_STEADY;
			hold_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ALPHA: alpha_q      <= cfg_data[ALPHA_W-1:0];
					CFG_T_MIN: t_min_q      <= cfg_data[TEMP_BITS-1:0];
					CFG_T_MAX: t_max_q      <= cfg_data[TEMP_BITS-1:0];
					CFG_HOLD:  hold_count_q <= cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end

			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (gauge.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ALPHA_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (op_q == OP_SAMPLE) begin
							ema_q    <= next_w;
							ema_ok_q <= !open_q;
							if (hold_q != '0) begin
								hold_q <= hold_q - HOLD_W'(1);
							end else begin
								trend_q <= trend_w;
								hold_q  <= hold_count_q;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign gauge.valid         = out_valid_q;
	assign gauge.red           = red_q;
	assign gauge.green         = green_q;
	assign gauge.blue          = blue_q;
	assign gauge.trend         = otrend_q;
	assign gauge.average       = avg_q;
	assign gauge.average_valid = avg_ok_q;

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN))
		else $error("accepted item did not start work");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!ema_ok_q |-> (ema_q == '0))
		else $error("invalid average is not zero");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (pct_w <= PCT_W'(FULL_PCT)))
		else $error("gauge percent out of range");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && gauge.ready && !commit) |=> !out_valid_q)
		else $error("taken result still shown");

endmodule
